// ----- sv/pic_pkg.sv -----
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types and constants of the platform interrupt controller: register
// map, bus op codes, decoded access kinds and the queued item format.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int DATA_W  = 32;
  localparam int SEL_W   = 6;
  localparam int OP_W    = 2;
  localparam int ID_W    = 5;   // source IDs 0..31
  localparam int MAX_SRC = 32;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [SEL_W-1:0] REG_ENABLE    = 6'd32;
  localparam logic [SEL_W-1:0] REG_THRESHOLD = 6'd33;
  localparam logic [SEL_W-1:0] REG_CLAIM     = 6'd34;

  typedef enum logic [3:0] {
    K_SAMPLE,
    K_WR_PRIO,
    K_WR_EN,
    K_WR_THR,
    K_COMPLETE,
    K_RD_PRIO,
    K_RD_EN,
    K_RD_THR,
    K_CLAIM
  } op_kind_e;

  typedef struct packed {
    op_kind_e          kind;
    logic [ID_W-1:0]   idx;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] lines;
  } item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SETTLE,
    B_RESOLVE
  } b_state_e;

endpackage

// ----- sv/pic_front.sv -----
// ----------------------------------------------------------------------------
// pic_front
// Accepts bus beats, decodes op and register select into an access kind and
// holds them in a two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module pic_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [pic_pkg::OP_W-1:0]     op_i,
  input  logic [pic_pkg::SEL_W-1:0]    reg_sel_i,
  input  logic [pic_pkg::DATA_W-1:0]   wdata_i,
  input  logic [pic_pkg::DATA_W-1:0]   irq_lines_i,
  output logic                         head_valid_o,
  output pic_pkg::item_t               head_o,
  input  logic                         pop_i
);

  pic_pkg::item_t   fifo_q [2];
  pic_pkg::item_t   item;
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push;

  always_comb begin
    item.kind  = pic_pkg::K_SAMPLE;
    item.idx   = reg_sel_i[pic_pkg::ID_W-1:0];
    item.wdata = wdata_i;
    item.lines = irq_lines_i;
    if (op_i == pic_pkg::OP_WRITE) begin
      if (reg_sel_i < pic_pkg::REG_ENABLE) begin
        item.kind = pic_pkg::K_WR_PRIO;
      end else begin
        case (reg_sel_i)
          pic_pkg::REG_ENABLE:    item.kind = pic_pkg::K_WR_EN;
          pic_pkg::REG_THRESHOLD: item.kind = pic_pkg::K_WR_THR;
          pic_pkg::REG_CLAIM:     item.kind = pic_pkg::K_COMPLETE;
          default:                item.kind = pic_pkg::K_SAMPLE;
        endcase
      end
    end else if (op_i == pic_pkg::OP_READ) begin
      if (reg_sel_i < pic_pkg::REG_ENABLE) begin
        item.kind = pic_pkg::K_RD_PRIO;
      end else begin
        case (reg_sel_i)
          pic_pkg::REG_ENABLE:    item.kind = pic_pkg::K_RD_EN;
          pic_pkg::REG_THRESHOLD: item.kind = pic_pkg::K_RD_THR;
          pic_pkg::REG_CLAIM:     item.kind = pic_pkg::K_CLAIM;
          default:                item.kind = pic_pkg::K_SAMPLE;
        endcase
      end
    end
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ----- sv/pic_search.sv -----
// ----------------------------------------------------------------------------
// pic_search
// Two-level priority search: groups of four candidates are resolved and
// registered, then the group winners are reduced to the best source ID.
// Ties go to the lowest ID.
// ----------------------------------------------------------------------------
module pic_search #(
  parameter int NSRC      = 32,
  parameter int PRIO_BITS = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [NSRC-1:0]            cand_i,
  input  logic [PRIO_BITS-1:0]       prio_i [NSRC],
  output logic                       found_o,
  output logic [pic_pkg::ID_W-1:0]   best_id_o
);

  localparam int NGRP  = (NSRC + 3) / 4;
  localparam int NSLOT = NGRP * 4;

  logic [NSLOT-1:0]          cand_s;
  logic [PRIO_BITS-1:0]      prio_s [NSLOT];
  logic                      grp_v_d  [NGRP];
  logic [PRIO_BITS-1:0]      grp_p_d  [NGRP];
  logic [pic_pkg::ID_W-1:0]  grp_id_d [NGRP];
  logic                      grp_v_q  [NGRP];
  logic [PRIO_BITS-1:0]      grp_p_q  [NGRP];
  logic [pic_pkg::ID_W-1:0]  grp_id_q [NGRP];
  logic [PRIO_BITS-1:0]      best_p;

  always_comb begin
    cand_s = NSLOT'(cand_i);
    for (int s = 0; s < NSLOT; s++) begin
      prio_s[s] = '0;
    end
    for (int s = 0; s < NSRC; s++) begin
      prio_s[s] = prio_i[s];
    end
  end

  // first level: winner of each group of four, scanned upward
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_v_d[g]  = 1'b0;
      grp_p_d[g]  = '0;
      grp_id_d[g] = '0;
      for (int j = 0; j < 4; j++) begin
        if (cand_s[g*4+j] && (!grp_v_d[g] || prio_s[g*4+j] > grp_p_d[g])) begin
          grp_v_d[g]  = 1'b1;
          grp_p_d[g]  = prio_s[g*4+j];
          grp_id_d[g] = pic_pkg::ID_W'(g*4+j);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_v_q[g] <= 1'b0;
      end
    end else begin
      for (int g = 0; g < NGRP; g++) begin
        grp_v_q[g] <= grp_v_d[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_p_q[g]  <= grp_p_d[g];
      grp_id_q[g] <= grp_id_d[g];
    end
  end

  // second level: reduce the registered group winners
  always_comb begin
    found_o   = 1'b0;
    best_p    = '0;
    best_id_o = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (grp_v_q[g] && (!found_o || grp_p_q[g] > best_p)) begin
        found_o   = 1'b1;
        best_p    = grp_p_q[g];
        best_id_o = grp_id_q[g];
      end
    end
  end

endmodule

// ----- sv/pic_back.sv -----
// ----------------------------------------------------------------------------
// pic_back
// Execution side: holds priorities, enables, threshold, pending and
// in-service bits, carries out one queued access at a time, runs the claim
// search and drives the result register.
// ----------------------------------------------------------------------------
module pic_back #(
  parameter int NUM_SOURCES = 32,
  parameter int PRIO_BITS   = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         head_valid_i,
  input  pic_pkg::item_t               head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pic_pkg::DATA_W-1:0]   rdata_o,
  output logic                         irq_out_o
);

  localparam int NSRC = (NUM_SOURCES < pic_pkg::MAX_SRC) ? NUM_SOURCES : pic_pkg::MAX_SRC;
  localparam int IDXW = $clog2(NSRC);
  localparam logic [NSRC-1:0] LIVE = {{(NSRC-1){1'b1}}, 1'b0};

  logic [PRIO_BITS-1:0]        prio_q [NSRC];
  logic [NSRC-1:0]             en_q, pend_q, insvc_q;
  logic [PRIO_BITS-1:0]        thr_q;
  logic                        claim_q;
  logic [pic_pkg::DATA_W-1:0]  res_rdata_q;
  logic                        out_valid_q, out_irq_q;
  logic [pic_pkg::DATA_W-1:0]  out_rdata_q;
  pic_pkg::b_state_e           state_q, state_d;

  logic                        do_access, do_claim, do_push, slot_free;
  logic [NSRC-1:0]             cand;
  logic                        found;
  logic [pic_pkg::ID_W-1:0]    best_id;
  logic                        sel_ok, cpl_ok;
  logic [IDXW-1:0]             sel_idx, best_idx;
  logic [pic_pkg::DATA_W-1:0]  rd_val;

  always_comb begin
    for (int n = 0; n < NSRC; n++) begin
      cand[n] = pend_q[n] && en_q[n] && LIVE[n] && (prio_q[n] > thr_q);
    end
  end

  pic_search #(
    .NSRC      (NSRC),
    .PRIO_BITS (PRIO_BITS)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cand_i    (cand),
    .prio_i    (prio_q),
    .found_o   (found),
    .best_id_o (best_id)
  );

  assign slot_free = !out_valid_q || !out_stall_i;
  assign sel_ok    = (int'(head_i.idx) < NSRC);
  assign sel_idx   = head_i.idx[IDXW-1:0];
  assign best_idx  = best_id[IDXW-1:0];
  assign cpl_ok    = (head_i.wdata[pic_pkg::DATA_W-1:pic_pkg::ID_W] == '0) &&
                     (int'(head_i.wdata[pic_pkg::ID_W-1:0]) < NSRC) &&
                     en_q[head_i.wdata[IDXW-1:0]];

  always_comb begin
    rd_val = '0;
    case (head_i.kind)
      pic_pkg::K_RD_PRIO: rd_val = sel_ok ? pic_pkg::DATA_W'(prio_q[sel_idx]) : '0;
      pic_pkg::K_RD_EN:   rd_val = pic_pkg::DATA_W'(en_q);
      pic_pkg::K_RD_THR:  rd_val = pic_pkg::DATA_W'(thr_q);
      default:            rd_val = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pic_pkg::B_IDLE: begin
        if (head_valid_i) begin
          state_d = pic_pkg::B_SETTLE;
        end
      end
      pic_pkg::B_SETTLE: state_d = pic_pkg::B_RESOLVE;
      pic_pkg::B_RESOLVE: begin
        if (claim_q) begin
          state_d = pic_pkg::B_SETTLE;
        end else if (slot_free) begin
          state_d = pic_pkg::B_IDLE;
        end
      end
      default: state_d = pic_pkg::B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    do_access = 1'b0;
    do_claim  = 1'b0;
    do_push   = 1'b0;
    case (state_q)
      pic_pkg::B_IDLE:    do_access = head_valid_i;
      pic_pkg::B_RESOLVE: begin
        do_claim = claim_q;
        do_push  = !claim_q && slot_free;
      end
      default: ;
    endcase
  end

  assign pop_o = do_access;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pic_pkg::B_IDLE;
      for (int n = 0; n < NSRC; n++) begin
        prio_q[n] <= '0;
      end
      en_q        <= '0;
      thr_q       <= '0;
      pend_q      <= '0;
      insvc_q     <= '0;
      claim_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_access) begin
        // sample lines first, then apply the access
        pend_q  <= pend_q | (head_i.lines[NSRC-1:0] & LIVE & ~insvc_q);
        claim_q <= (head_i.kind == pic_pkg::K_CLAIM);
        case (head_i.kind)
          pic_pkg::K_WR_PRIO: begin
            if (sel_ok && LIVE[sel_idx]) begin
              prio_q[sel_idx] <= head_i.wdata[PRIO_BITS-1:0];
            end
          end
          pic_pkg::K_WR_EN:  en_q  <= head_i.wdata[NSRC-1:0] & LIVE;
          pic_pkg::K_WR_THR: thr_q <= head_i.wdata[PRIO_BITS-1:0];
          pic_pkg::K_COMPLETE: begin
            if (cpl_ok) begin
              insvc_q[head_i.wdata[IDXW-1:0]] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (do_claim) begin
        claim_q <= 1'b0;
        if (found) begin
          pend_q[best_idx]  <= 1'b0;
          insvc_q[best_idx] <= 1'b1;
        end
      end
      if (do_push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_access) begin
      res_rdata_q <= rd_val;
    end else if (do_claim) begin
      res_rdata_q <= found ? pic_pkg::DATA_W'(best_id) : '0;
    end
    if (do_push) begin
      out_rdata_q <= res_rdata_q;
      out_irq_q   <= found;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rdata_o     = out_rdata_q;
  assign irq_out_o   = out_irq_q;

endmodule

// ----- sv/platform_interrupt_controller.sv -----
// Accesses run one at a time: each passes the input queue, the access step, a
// settle state that waits for the registered group stage of the two-level priority
// search, and a resolve state that waits out an output stall; claim reads settle
// and resolve once more. A two-entry input queue and the result register let each
// side stall on its own. Reset: asynchronous, active low; all priorities, enables,
// threshold, pending and in-service bits clear at once, with no clearing pass.
// ----------------------------------------------------------------------------
// platform_interrupt_controller
// Single-context platform interrupt controller: decode queue in front,
// register file, claim/complete logic and priority search behind it.
// ----------------------------------------------------------------------------
module platform_interrupt_controller #(
  parameter int NUM_SOURCES = 32,
  parameter int PRIO_BITS   = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [pic_pkg::OP_W-1:0]     op_i,
  input  logic [pic_pkg::SEL_W-1:0]    reg_sel_i,
  input  logic [pic_pkg::DATA_W-1:0]   wdata_i,
  input  logic [pic_pkg::DATA_W-1:0]   irq_lines_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pic_pkg::DATA_W-1:0]   rdata_o,
  output logic                         irq_out_o
);

  logic            head_valid;
  logic            pop;
  pic_pkg::item_t  head;

  pic_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .reg_sel_i    (reg_sel_i),
    .wdata_i      (wdata_i),
    .irq_lines_i  (irq_lines_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  pic_back #(
    .NUM_SOURCES (NUM_SOURCES),
    .PRIO_BITS   (PRIO_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rdata_o      (rdata_o),
    .irq_out_o    (irq_out_o)
  );

endmodule
